// ===== sv/touch_pressure_qualify_average_defines.svh =====
// shared assertion macros for the touch pressure block
`ifndef TOUCH_PRESSURE_QUALIFY_AVERAGE_DEFINES_SVH
`define TOUCH_PRESSURE_QUALIFY_AVERAGE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TPQA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpqa assertion failed");

// next-cycle implication
`define TPQA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpqa assertion failed");

`endif

// ===== sv/tpqa_pkg.sv =====
`default_nettype none

package tpqa_pkg;

    localparam int READ_W = 12;
    localparam int PRES_W = 13;

    localparam logic [7:0] CMD_X  = 8'hD0;
    localparam logic [7:0] CMD_Y  = 8'h90;
    localparam logic [7:0] CMD_Z1 = 8'hB0;
    localparam logic [7:0] CMD_Z2 = 8'hC0;

    localparam logic [PRES_W-1:0] FULL_SCALE = 13'd4095;
    localparam logic [PRES_W-1:0] THR_RESET  = 13'd400;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        transfer_ok;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        next_command;
        logic              report_valid;
        logic              pressed;
        logic [PRES_W-1:0] pressure;
        logic [READ_W-1:0] x_raw;
        logic [READ_W-1:0] y_raw;
    } t_out_beat;

    // report fields leaving the sequencer, before averaging
    typedef struct packed {
        logic [7:0]        next_command;
        logic              report_valid;
        logic              pressed;
        logic [PRES_W-1:0] pressure;
    } t_rpt;

endpackage

`default_nettype wire

// ===== sv/tpqa_seq.sv =====
`default_nettype none

module tpqa_seq
    import tpqa_pkg::*;
#(
    parameter int SAMPLE_PAIRS = 4,
    parameter int SUM_W        = READ_W + $clog2(SAMPLE_PAIRS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire t_in_beat          i_beat,
    input  wire logic              i_cfg_we,
    input  wire logic [PRES_W-1:0] i_cfg_data,
    output t_rpt                   o_rpt,
    output logic [SUM_W-1:0]       o_x_sum,
    output logic [SUM_W-1:0]       o_y_sum
);

`include "touch_pressure_qualify_average_defines.svh"

    localparam int STEP_W = $clog2(2 * SAMPLE_PAIRS + 2);
    localparam logic [STEP_W-1:0] STEP_Z2    = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(2 * SAMPLE_PAIRS + 1);

    logic [PRES_W-1:0] r_thr;
    logic [STEP_W-1:0] r_step, n_step;
    logic [READ_W-1:0] r_z1, n_z1;
    logic [PRES_W-1:0] r_held, n_held;
    logic [SUM_W-1:0]  r_xs, n_xs;
    logic [SUM_W-1:0]  r_ys, n_ys;
    t_rpt              r_rpt, n_rpt;
    logic [SUM_W-1:0]  r_xo, r_yo;

    logic [READ_W-1:0] reading;
    logic [PRES_W-1:0] z_raw;
    logic [PRES_W-1:0] z;

    // bit 15 of the frame is dropped, failed transfers read zero
    assign reading = i_beat.transfer_ok ? i_beat.frame_word[14:3] : '0;
    assign z_raw   = {1'b0, r_z1} + FULL_SCALE - {1'b0, reading};
    assign z       = (r_z1 == '0) ? '0 : z_raw;

    always_comb begin
        n_step = r_step;
        n_z1   = r_z1;
        n_held = r_held;
        n_xs   = r_xs;
        n_ys   = r_ys;
        n_rpt.next_command = CMD_Z2;
        n_rpt.report_valid = 1'b0;
        n_rpt.pressed      = 1'b0;
        n_rpt.pressure     = '0;
        if (r_step == STEP_Z2) begin
            if (z < r_thr) begin
                n_rpt.report_valid = 1'b1;
                n_rpt.pressure     = z;
                n_rpt.next_command = CMD_Z1;
                n_step             = '0;
            end else begin
                n_held             = z;
                n_xs               = '0;
                n_ys               = '0;
                n_rpt.next_command = CMD_X;
                n_step             = STEP_FIRST;
            end
        end else if (r_step >= STEP_FIRST && r_step <= STEP_LAST) begin
            // even step index is an x sample, odd is y
            if (!r_step[0]) begin
                n_xs               = r_xs + SUM_W'(reading);
                n_rpt.next_command = CMD_Y;
                n_step             = r_step + STEP_W'(1);
            end else begin
                n_ys = r_ys + SUM_W'(reading);
                if (r_step == STEP_LAST) begin
                    n_rpt.report_valid = 1'b1;
                    n_rpt.pressed      = 1'b1;
                    n_rpt.pressure     = r_held;
                    n_rpt.next_command = CMD_Z1;
                    n_step             = '0;
                end else begin
                    n_rpt.next_command = CMD_X;
                    n_step             = r_step + STEP_W'(1);
                end
            end
        end else begin
            n_z1   = reading;
            n_step = STEP_Z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_step <= '0;
            r_z1   <= '0;
            r_held <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_take) begin
                r_step <= n_step;
                r_z1   <= n_z1;
                r_held <= n_held;
                r_xs   <= n_xs;
                r_ys   <= n_ys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_rpt <= n_rpt;
            r_xo  <= n_xs;
            r_yo  <= n_ys;
        end
    end

    assign o_rpt   = r_rpt;
    assign o_x_sum = r_xo;
    assign o_y_sum = r_yo;

    `TPQA_ASSERT_NOW(a_step_range, 1'b1, r_step <= STEP_LAST)
    `TPQA_ASSERT_NEXT(a_report_restarts, i_take && n_rpt.report_valid, r_step == '0)
    `TPQA_ASSERT_NOW(a_pressed_on_last, i_take && n_rpt.pressed, r_step == STEP_LAST)

endmodule

`default_nettype wire

// ===== sv/tpqa_avg.sv =====
`default_nettype none

module tpqa_avg
    import tpqa_pkg::*;
#(
    parameter int SAMPLE_PAIRS = 4,
    parameter int SUM_W        = READ_W + $clog2(SAMPLE_PAIRS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_load,
    input  wire t_rpt             i_rpt,
    input  wire logic [SUM_W-1:0] i_x_sum,
    input  wire logic [SUM_W-1:0] i_y_sum,
    output t_out_beat             o_beat
);

    // divide by a constant through a rounded-up reciprocal, exact for any sum
    localparam int SH   = SUM_W + $clog2(SAMPLE_PAIRS);
    localparam int PW   = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RECIP =
        (SUM_W + 1)'(((1 << SH) + SAMPLE_PAIRS - 1) / SAMPLE_PAIRS);

    logic [PW-1:0]     x_prod, y_prod;
    logic [READ_W-1:0] x_avg, y_avg;
    t_out_beat         r_beat;

    assign x_prod = PW'(i_x_sum) * PW'(RECIP);
    assign y_prod = PW'(i_y_sum) * PW'(RECIP);
    assign x_avg  = x_prod[SH +: READ_W];
    assign y_avg  = y_prod[SH +: READ_W];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat.next_command <= i_rpt.next_command;
            r_beat.report_valid <= i_rpt.report_valid;
            r_beat.pressed      <= i_rpt.pressed;
            r_beat.pressure     <= i_rpt.pressure;
            r_beat.x_raw        <= i_rpt.pressed ? x_avg : '0;
            r_beat.y_raw        <= i_rpt.pressed ? y_avg : '0;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== sv/touch_pressure_qualify_average.sv =====
// Qualifies resistive touch conversions and averages coordinates. Each input
// beat is one finished conversion frame; each one yields exactly one output
// beat naming the next conversion command, and on a Z2 sample below the
// threshold or the last Y sample a released or pressed report. One beat is
// taken every clock cycle unless the output stalls; a result passes two
// registers: the sequencer state update fills the first register, the
// reciprocal multiply for the averages fills the output register. The
// threshold register is written through the config channel, always ready.
`default_nettype none

module touch_pressure_qualify_average
    import tpqa_pkg::*;
#(
    parameter int SAMPLE_PAIRS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_beat          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_beat              o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [PRES_W-1:0] i_cfg_data
);

`include "touch_pressure_qualify_average_defines.svh"

    localparam int SUM_W = READ_W + $clog2(SAMPLE_PAIRS);

    logic             r_s1_vld;
    logic             r_out_vld;
    logic             out_load;
    logic             s1_adv;
    logic             take;
    t_rpt             s1_rpt;
    logic [SUM_W-1:0] s1_x_sum, s1_y_sum;

    assign out_load    = !r_out_vld || !i_out_stall;
    assign s1_adv      = r_s1_vld && out_load;
    assign o_in_stall  = r_s1_vld && !out_load;
    assign take        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take || s1_adv) begin
                r_s1_vld <= take;
            end
            if (out_load) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    tpqa_seq #(
        .SAMPLE_PAIRS(SAMPLE_PAIRS),
        .SUM_W       (SUM_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_beat    (i_in_data),
        .i_cfg_we  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_rpt     (s1_rpt),
        .o_x_sum   (s1_x_sum),
        .o_y_sum   (s1_y_sum)
    );

    tpqa_avg #(
        .SAMPLE_PAIRS(SAMPLE_PAIRS),
        .SUM_W       (SUM_W)
    ) u_avg (
        .i_clk  (i_clk),
        .i_load (s1_adv),
        .i_rpt  (s1_rpt),
        .i_x_sum(s1_x_sum),
        .i_y_sum(s1_y_sum),
        .o_beat (o_out_data)
    );

    `TPQA_ASSERT_NOW(a_full_pipe_stalls, r_s1_vld && r_out_vld && i_out_stall, o_in_stall)
    `TPQA_ASSERT_NOW(a_idle_fields_zero, o_out_valid && !o_out_data.report_valid,
        !o_out_data.pressed && o_out_data.pressure == '0)
    `TPQA_ASSERT_NOW(a_released_coords_zero, o_out_valid && !o_out_data.pressed,
        o_out_data.x_raw == '0 && o_out_data.y_raw == '0)
    `TPQA_ASSERT_NEXT(a_stage_moves, s1_adv, o_out_valid)

endmodule

`default_nettype wire

// ===== verif/touch_pressure_qualify_average_test.sv =====
module touch_pressure_qualify_average_test;
    import tpqa_pkg::*;

    localparam int SAMPLE_PAIRS = 4;
    localparam int LAST_STEP    = 2 + 2 * SAMPLE_PAIRS - 1;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 175;
    localparam int MAX_PRINTS   = 40;

    class touch_report_scoreboard;
        logic [PRES_W-1:0] threshold;
        logic [3:0]        step;
        logic [READ_W-1:0] z1_held;
        logic [PRES_W-1:0] pressure_held;
        logic [15:0]       x_acc;
        logic [15:0]       y_acc;
        t_out_beat         expected_q[$];
        int                errors;

        function new();
            threshold     = THR_RESET;
            step          = '0;
            z1_held       = '0;
            pressure_held = '0;
            x_acc         = '0;
            y_acc         = '0;
            errors        = 0;
        endfunction

        function void set_threshold(logic [PRES_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // works out the result of one accepted conversion and advances the sequence
        function void note_reading(t_in_beat b);
            logic [READ_W-1:0] reading;
            logic [PRES_W-1:0] z;
            t_out_beat         res;
            reading = b.transfer_ok ? b.frame_word[14:3] : '0;
            res = '0;
            if (step == 1) begin
                z = {1'b0, z1_held} + FULL_SCALE - {1'b0, reading};
                if (z1_held == 0) begin
                    z = '0;
                end
                if (z < threshold) begin
                    res.report_valid = 1'b1;
                    res.pressure     = z;
                    res.next_command = CMD_Z1;
                    step             = 4'd0;
                end else begin
                    pressure_held    = z;
                    x_acc            = '0;
                    y_acc            = '0;
                    res.next_command = CMD_X;
                    step             = 4'd2;
                end
            end else if (step >= 2 && step <= LAST_STEP) begin
                if (step[0] == 1'b0) begin
                    x_acc            = x_acc + reading;
                    res.next_command = CMD_Y;
                    step             = step + 4'd1;
                end else begin
                    y_acc = y_acc + reading;
                    if (step == LAST_STEP) begin
                        res.report_valid = 1'b1;
                        res.pressed      = 1'b1;
                        res.pressure     = pressure_held;
                        res.x_raw        = READ_W'(x_acc / SAMPLE_PAIRS);
                        res.y_raw        = READ_W'(y_acc / SAMPLE_PAIRS);
                        res.next_command = CMD_Z1;
                        step             = 4'd0;
                    end else begin
                        res.next_command = CMD_X;
                        step             = step + 4'd1;
                    end
                end
            end else begin
                z1_held          = reading;
                res.next_command = CMD_Z2;
                step             = 4'd1;
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            if (errors < MAX_PRINTS) begin
                $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
            end
            errors++;
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.next_command !== want.next_command)
                report_mismatch("next_command", got.next_command, want.next_command);
            if (got.report_valid !== want.report_valid)
                report_mismatch("report_valid", got.report_valid, want.report_valid);
            if (got.pressed !== want.pressed)
                report_mismatch("pressed", got.pressed, want.pressed);
            if (got.pressure !== want.pressure)
                report_mismatch("pressure", got.pressure, want.pressure);
            if (got.x_raw !== want.x_raw)
                report_mismatch("x_raw", got.x_raw, want.x_raw);
            if (got.y_raw !== want.y_raw)
                report_mismatch("y_raw", got.y_raw, want.y_raw);
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_beat          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_beat         o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PRES_W-1:0] i_cfg_data  = '0;

    touch_report_scoreboard sb = new();

    int unsigned in_gap_max  = 17;
    int unsigned out_gap_max = 17;
    int unsigned items_sent  = 0;
    logic        rx_hold     = 1'b0;

    touch_pressure_qualify_average #(
        .SAMPLE_PAIRS (SAMPLE_PAIRS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_reading(input t_in_beat b);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_reading(b);
        items_sent++;
    endtask

    // only between phases, once every outstanding beat has come back
    task automatic write_threshold(input logic [PRES_W-1:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_threshold(value);
    endtask

    function automatic t_in_beat random_reading();
        t_in_beat    b;
        int unsigned roll;
        int          target;
        int          r;
        roll = $urandom_range(0, 99);
        b.transfer_ok = ($urandom_range(0, 9) != 0);
        if (roll < 8)
            b.frame_word = 16'h0000;
        else if (roll < 16)
            b.frame_word = 16'hFFFF;
        else if (roll < 24)
            b.frame_word = 16'($urandom_range(0, 15));
        else
            b.frame_word = 16'($urandom);
        // z2 next: aim the pressure right around the threshold
        if (sb.step == 1 && roll >= 60 && sb.z1_held != 0) begin
            target = int'(sb.threshold) + int'($urandom_range(0, 4)) - 2;
            r = int'(sb.z1_held) + 4095 - target;
            if (r < 0) r = 0;
            if (r > 4095) r = 4095;
            b.frame_word = {1'($urandom_range(0, 1)), 12'(r), 3'($urandom_range(0, 7))};
            b.transfer_ok = 1'b1;
        end
        return b;
    endfunction

    // receiver: random stall per beat, plus a long hold-off on request
    initial begin : receiver
        int unsigned wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
                wait_left = $urandom_range(0, out_gap_max);
            end else if (wait_left != 0) begin
                wait_left--;
            end
            i_out_stall <= rx_hold || (wait_left != 0);
        end
    end

    // back up the block so it has to stall its input
    initial begin : hold_off
        wait (items_sent >= 400);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** touch_pressure_qualify_average: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [PRES_W-1:0] thresholds[9];
        thresholds[0] = 13'd0;
        thresholds[1] = 13'd8191;
        thresholds[2] = 13'd1;
        thresholds[3] = 13'd8190;
        thresholds[4] = 13'd4095;
        thresholds[5] = 13'($urandom_range(0, 8191));
        thresholds[6] = 13'($urandom_range(0, 1000));
        thresholds[7] = 13'($urandom_range(3000, 8191));
        thresholds[8] = THR_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // z1 of zero forces zero pressure
        send_reading('{16'h0000, 1'b1});
        send_reading('{16'hFFFF, 1'b1});
        // failed z1 reads as zero
        send_reading('{16'hFFFF, 1'b0});
        send_reading('{16'h1230, 1'b1});
        // full-scale z1 with top bit set, zero z2: maximum pressure
        send_reading('{16'hFFFF, 1'b1});
        send_reading('{16'h0000, 1'b1});
        send_reading('{16'hFFFF, 1'b1});
        send_reading('{16'h7FF8, 1'b1});
        send_reading('{16'h8007, 1'b1});
        send_reading('{16'hFFFF, 1'b0});
        send_reading('{16'h1234, 1'b1});
        send_reading('{16'hABCD, 1'b1});
        send_reading('{16'hFFF8, 1'b1});
        send_reading('{16'h0007, 1'b1});
        // one below the reset threshold, then exactly on it
        send_reading('{16'(100 << 3), 1'b1});
        send_reading('{16'(3796 << 3), 1'b1});
        send_reading('{16'(100 << 3), 1'b1});
        send_reading('{16'(3795 << 3), 1'b1});
        repeat (2 * SAMPLE_PAIRS) send_reading(random_reading());

        for (int p = 0; p < 9; p++) begin
            write_threshold(thresholds[p]);
            case (p % 4)
                0: begin in_gap_max = 17; out_gap_max = 17; end
                1: begin in_gap_max = 0;  out_gap_max = 0;  end
                2: begin in_gap_max = 0;  out_gap_max = 17; end
                default: begin in_gap_max = 17; out_gap_max = 0; end
            endcase
            repeat (PHASE_ITEMS) send_reading(random_reading());
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** touch_pressure_qualify_average: PASSED **");
        else
            $display("** touch_pressure_qualify_average: FAILED **");
        $finish;
    end

endmodule
